/* sv/csdf_pkg.sv */
package csdf_pkg;

  // Fixed vector format: three signed components, x in the lowest bits.
  localparam int unsigned COMPONENT_BITS    = 20;
  localparam int unsigned VEC_W             = 3 * COMPONENT_BITS;
  localparam int unsigned FRACTION_BITS_DEF = 12;

  // Gains and the saturation width of the damping path.
  localparam int unsigned GAIN_BITS  = 10;
  localparam int unsigned INNER_BITS = 40;
  // The 40-bit projection is split here so each multiply stays narrow.
  localparam int unsigned INNER_LO   = 20;

  localparam logic [GAIN_BITS-1:0] SPRING_GAIN_RST = 10'd160;
  localparam logic [GAIN_BITS-1:0] DAMPER_GAIN_RST = 10'd8;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPRING_GAIN = 2'd0,
    REG_DAMPER_GAIN = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [VEC_W-1:0]          contact_point;
    logic [VEC_W-1:0]          contact_normal;
    logic [COMPONENT_BITS-1:0] penetration;
    logic [VEC_W-1:0]          master_position;
    logic [VEC_W-1:0]          master_velocity;
    logic [VEC_W-1:0]          master_spin;
    logic [VEC_W-1:0]          sub_position;
    logic [VEC_W-1:0]          sub_velocity;
    logic [VEC_W-1:0]          sub_spin;
  } in_item_t;

  typedef struct packed {
    logic [VEC_W-1:0] master_force;
    logic [VEC_W-1:0] master_torque;
    logic [VEC_W-1:0] sub_force;
    logic [VEC_W-1:0] sub_torque;
  } out_item_t;

  // Width of the relative contact velocity for a given fraction width.
  function automatic int unsigned rel_width(input int unsigned fb);
    int unsigned cr;
    int unsigned pv;
    cr = 2 * COMPONENT_BITS + 2 - fb;
    pv = ((cr > COMPONENT_BITS) ? cr : COMPONENT_BITS) + 1;
    return pv + 1;
  endfunction

  // Clamp a signed value to a signed range of the given width.
  function automatic logic signed [63:0] sat_wide(input logic signed [63:0] v,
                                                 input int unsigned width);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (width - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

/* sv/csdf_cross.sv */
module csdf_cross #(
  parameter int unsigned A_W           = 20,
  parameter int unsigned B_W           = 21,
  parameter int unsigned FRACTION_BITS = csdf_pkg::FRACTION_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic [1:0]                             en_i,
  input  logic signed [A_W-1:0]                  a_i [3],
  input  logic signed [B_W-1:0]                  b_i [3],
  output logic signed [A_W+B_W-FRACTION_BITS:0]  r_o [3]
);

  localparam int unsigned P_W = A_W + B_W;

  logic signed [P_W-1:0] prod_q [6];
  logic signed [P_W:0]   diff   [3];

  // First stage: the six partial products of a x b.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q[0] <= a_i[1] * b_i[2];
      prod_q[1] <= a_i[2] * b_i[1];
      prod_q[2] <= a_i[2] * b_i[0];
      prod_q[3] <= a_i[0] * b_i[2];
      prod_q[4] <= a_i[0] * b_i[1];
      prod_q[5] <= a_i[1] * b_i[0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = (P_W+1)'(prod_q[2*i]) - (P_W+1)'(prod_q[2*i+1]);
    end
  end

  // Second stage: differences rescaled by an arithmetic shift.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int i = 0; i < 3; i++) begin
        r_o[i] <= diff[i][P_W:FRACTION_BITS];
      end
    end
  end

endmodule

/* sv/csdf_force.sv */
module csdf_force #(
  parameter int unsigned FRACTION_BITS = csdf_pkg::FRACTION_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic [5:0]                                 en_i,
  input  logic [csdf_pkg::GAIN_BITS-1:0]             spring_gain_i,
  input  logic [csdf_pkg::GAIN_BITS-1:0]             damper_gain_i,
  input  logic signed [csdf_pkg::rel_width(FRACTION_BITS)-1:0] rel_i [3],
  input  logic signed [csdf_pkg::COMPONENT_BITS-1:0] normal_i [3],
  input  logic signed [csdf_pkg::COMPONENT_BITS-1:0] pen_i,
  output logic signed [csdf_pkg::COMPONENT_BITS-1:0] master_force_o [3],
  output logic signed [csdf_pkg::COMPONENT_BITS-1:0] sub_force_o [3]
);

  localparam int unsigned CB    = csdf_pkg::COMPONENT_BITS;
  localparam int unsigned GB    = csdf_pkg::GAIN_BITS;
  localparam int unsigned IN_W  = csdf_pkg::INNER_BITS;
  localparam int unsigned LO_W  = csdf_pkg::INNER_LO;
  localparam int unsigned REL_W = csdf_pkg::rel_width(FRACTION_BITS);
  localparam int unsigned DP_W  = REL_W + CB;
  localparam int unsigned NP_W  = 2 * CB;
  localparam int unsigned SP_W  = NP_W + GB + 1;
  localparam int unsigned PL_W  = CB + LO_W + 1;
  localparam int unsigned PH_W  = CB + IN_W - LO_W;
  localparam int unsigned CVC_W = IN_W + GB + 1;

  logic signed [DP_W-1:0]  dp_q   [3];
  logic signed [NP_W-1:0]  np_q   [3];
  logic signed [CB-1:0]    n4_q   [3];
  logic signed [IN_W-1:0]  dot_q;
  logic signed [SP_W-1:0]  npk_q  [3];
  logic signed [CB-1:0]    n5_q   [3];
  logic signed [PL_W-1:0]  pl_q   [3];
  logic signed [PH_W-1:0]  ph_q   [3];
  logic signed [SP_W-1:0]  sp6_q  [3];
  logic signed [IN_W-1:0]  cv_q   [3];
  logic signed [SP_W-1:0]  sp7_q  [3];
  logic signed [CVC_W-1:0] cvc_q  [3];
  logic signed [SP_W-1:0]  sp8_q  [3];
  logic signed [63:0]      dot_sum;
  logic signed [CB-1:0]    fm_d   [3];

  // Products of the velocity projection and of normal times depth.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        dp_q[i] <= rel_i[i] * normal_i[i];
        np_q[i] <= normal_i[i] * pen_i;
        n4_q[i] <= normal_i[i];
      end
    end
  end

  assign dot_sum = 64'(dp_q[0]) + 64'(dp_q[1]) + 64'(dp_q[2]);

  // Normal speed, rescaled and clamped; spring term scaled by the stiffness.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      dot_q <= IN_W'(csdf_pkg::sat_wide(dot_sum >>> FRACTION_BITS, IN_W));
      for (int i = 0; i < 3; i++) begin
        npk_q[i] <= np_q[i] * $signed({1'b0, spring_gain_i});
        n5_q[i]  <= n4_q[i];
      end
    end
  end

  // Normal times normal speed, as two half-width products.
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int i = 0; i < 3; i++) begin
        pl_q[i]  <= n5_q[i] * $signed({1'b0, dot_q[LO_W-1:0]});
        ph_q[i]  <= n5_q[i] * $signed(dot_q[IN_W-1:LO_W]);
        sp6_q[i] <= npk_q[i] >>> FRACTION_BITS;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      for (int i = 0; i < 3; i++) begin
        cv_q[i]  <= IN_W'(csdf_pkg::sat_wide(
                      ((64'(ph_q[i]) <<< LO_W) + 64'(pl_q[i])) >>> FRACTION_BITS, IN_W));
        sp7_q[i] <= sp6_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      for (int i = 0; i < 3; i++) begin
        cvc_q[i] <= cv_q[i] * $signed({1'b0, damper_gain_i});
        sp8_q[i] <= sp7_q[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fm_d[i] = CB'(csdf_pkg::sat_wide(64'(sp8_q[i]) - 64'(cvc_q[i]), CB));
    end
  end

  // Master force, and the sub force as its clamped negation.
  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      for (int i = 0; i < 3; i++) begin
        master_force_o[i] <= fm_d[i];
        sub_force_o[i]    <= CB'(csdf_pkg::sat_wide(-64'(fm_d[i]), CB));
      end
    end
  end

endmodule

/* sv/contact_spring_damper_force.sv */
// Throughput: one item per cycle; every stage advances whenever the stage after it
// is empty or advancing, so only output back-pressure stalls the pipeline.
// The multipliers of the cross-product units and of the force unit set the depth.
// Reset clears all stage valid bits and loads the gains with 160 and 8.
module contact_spring_damper_force #(
  parameter int unsigned FRACTION_BITS = csdf_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  csdf_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output csdf_pkg::out_item_t              out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [csdf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [csdf_pkg::GAIN_BITS-1:0]   cfg_data_i
);

  localparam int unsigned CB     = csdf_pkg::COMPONENT_BITS;
  localparam int unsigned GB     = csdf_pkg::GAIN_BITS;
  localparam int unsigned ARM_W  = CB + 1;
  localparam int unsigned CR_W   = CB + ARM_W + 1 - FRACTION_BITS;
  localparam int unsigned REL_W  = csdf_pkg::rel_width(FRACTION_BITS);

  // Stage map: 0 lever arms, 1-2 spin x arm, 3 relative velocity,
  // 4-9 force unit, 10-11 arm x force, 12 torque clamp and output register.
  localparam int unsigned STAGES = 13;
  localparam int unsigned ST_REL = 3;
  localparam int unsigned ST_FLO = 4;
  localparam int unsigned ST_FHI = 9;
  localparam int unsigned ST_TQ  = 10;
  localparam int unsigned ST_OUT = 12;

  logic [STAGES-1:0] valid_q;
  logic [STAGES-1:0] valid_d;
  logic [STAGES-1:0] en;

  logic [GB-1:0] spring_gain_q;
  logic [GB-1:0] damper_gain_q;

  // Unpacked input components.
  logic signed [CB-1:0] pt_c  [3];
  logic signed [CB-1:0] n_c   [3];
  logic signed [CB-1:0] mp_c  [3];
  logic signed [CB-1:0] mv_c  [3];
  logic signed [CB-1:0] mw_c  [3];
  logic signed [CB-1:0] sp_c  [3];
  logic signed [CB-1:0] sv_c  [3];
  logic signed [CB-1:0] sw_c  [3];

  // Delay lines that carry operands alongside the arithmetic.
  logic signed [ARM_W-1:0] arm_m_q [ST_FHI+1][3];
  logic signed [ARM_W-1:0] arm_s_q [ST_FHI+1][3];
  logic signed [CB-1:0]    vel_m_q [ST_REL][3];
  logic signed [CB-1:0]    vel_s_q [ST_REL][3];
  logic signed [CB-1:0]    spin_m_q [3];
  logic signed [CB-1:0]    spin_s_q [3];
  logic signed [CB-1:0]    nrm_q   [ST_REL+1][3];
  logic signed [CB-1:0]    pen_q   [ST_REL+1];

  logic signed [CR_W-1:0]  cr_m [3];
  logic signed [CR_W-1:0]  cr_s [3];
  logic signed [REL_W-1:0] rel_q [3];

  logic signed [CB-1:0]    fm_9 [3];
  logic signed [CB-1:0]    fs_9 [3];
  logic signed [CB-1:0]    fm_q [ST_OUT-ST_TQ+1][3];
  logic signed [CB-1:0]    fs_q [ST_OUT-ST_TQ+1][3];
  logic signed [CR_W-1:0]  tq_m [3];
  logic signed [CR_W-1:0]  tq_s [3];
  logic signed [CB-1:0]    tm_q [3];
  logic signed [CB-1:0]    ts_q [3];

  // Configuration writes are always taken; an unknown index is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spring_gain_q <= csdf_pkg::SPRING_GAIN_RST;
      damper_gain_q <= csdf_pkg::DAMPER_GAIN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        csdf_pkg::REG_SPRING_GAIN: spring_gain_q <= cfg_data_i;
        csdf_pkg::REG_DAMPER_GAIN: damper_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its contents move on. The chain runs from
  // the output backward, so bubbles anywhere in the pipe are squeezed out.
  always_comb begin
    en[STAGES-1] = !valid_q[STAGES-1] || out_ready_i;
    for (int s = STAGES - 2; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int s = 1; s < STAGES; s++) begin
      if (en[s]) begin
        valid_d[s] = valid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[ST_OUT];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt_c[i] = $signed(in_item_i.contact_point[i*CB +: CB]);
      n_c[i]  = $signed(in_item_i.contact_normal[i*CB +: CB]);
      mp_c[i] = $signed(in_item_i.master_position[i*CB +: CB]);
      mv_c[i] = $signed(in_item_i.master_velocity[i*CB +: CB]);
      mw_c[i] = $signed(in_item_i.master_spin[i*CB +: CB]);
      sp_c[i] = $signed(in_item_i.sub_position[i*CB +: CB]);
      sv_c[i] = $signed(in_item_i.sub_velocity[i*CB +: CB]);
      sw_c[i] = $signed(in_item_i.sub_spin[i*CB +: CB]);
    end
  end

  // Stage 0 forms the lever arms from the body centers to the contact point.
  // Later stages just hand the operands along until they are needed.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        arm_m_q[0][i] <= ARM_W'(pt_c[i]) - ARM_W'(mp_c[i]);
        arm_s_q[0][i] <= ARM_W'(pt_c[i]) - ARM_W'(sp_c[i]);
        vel_m_q[0][i] <= mv_c[i];
        vel_s_q[0][i] <= sv_c[i];
        spin_m_q[i]   <= mw_c[i];
        spin_s_q[i]   <= sw_c[i];
        nrm_q[0][i]   <= n_c[i];
      end
      pen_q[0] <= $signed(in_item_i.penetration);
    end
    for (int s = 1; s <= ST_FHI; s++) begin
      if (en[s]) begin
        arm_m_q[s] <= arm_m_q[s-1];
        arm_s_q[s] <= arm_s_q[s-1];
      end
    end
    for (int s = 1; s < ST_REL; s++) begin
      if (en[s]) begin
        vel_m_q[s] <= vel_m_q[s-1];
        vel_s_q[s] <= vel_s_q[s-1];
      end
    end
    for (int s = 1; s <= ST_REL; s++) begin
      if (en[s]) begin
        nrm_q[s] <= nrm_q[s-1];
        pen_q[s] <= pen_q[s-1];
      end
    end
  end

  // Stages 1 and 2: spin x arm for each body.
  csdf_cross #(
    .A_W           (CB),
    .B_W           (ARM_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cross_pv_m (
    .clk_i (clk_i),
    .en_i  (en[2:1]),
    .a_i   (spin_m_q),
    .b_i   (arm_m_q[0]),
    .r_o   (cr_m)
  );

  csdf_cross #(
    .A_W           (CB),
    .B_W           (ARM_W),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cross_pv_s (
    .clk_i (clk_i),
    .en_i  (en[2:1]),
    .a_i   (spin_s_q),
    .b_i   (arm_s_q[0]),
    .r_o   (cr_s)
  );

  // Stage 3: contact point velocity of the master minus that of the sub.
  always_ff @(posedge clk_i) begin
    if (en[ST_REL]) begin
      for (int i = 0; i < 3; i++) begin
        rel_q[i] <= REL_W'(cr_m[i]) + REL_W'(vel_m_q[ST_REL-1][i])
                  - REL_W'(cr_s[i]) - REL_W'(vel_s_q[ST_REL-1][i]);
      end
    end
  end

  // Stages 4 to 9: normal projection, spring and damper, both forces.
  csdf_force #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_force (
    .clk_i          (clk_i),
    .en_i           (en[ST_FHI:ST_FLO]),
    .spring_gain_i  (spring_gain_q),
    .damper_gain_i  (damper_gain_q),
    .rel_i          (rel_q),
    .normal_i       (nrm_q[ST_REL]),
    .pen_i          (pen_q[ST_REL]),
    .master_force_o (fm_9),
    .sub_force_o    (fs_9)
  );

  // Stages 10 and 11: arm x force for each body, using the clamped forces.
  csdf_cross #(
    .A_W           (ARM_W),
    .B_W           (CB),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cross_tq_m (
    .clk_i (clk_i),
    .en_i  (en[ST_TQ+1:ST_TQ]),
    .a_i   (arm_m_q[ST_FHI]),
    .b_i   (fm_9),
    .r_o   (tq_m)
  );

  csdf_cross #(
    .A_W           (ARM_W),
    .B_W           (CB),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cross_tq_s (
    .clk_i (clk_i),
    .en_i  (en[ST_TQ+1:ST_TQ]),
    .a_i   (arm_s_q[ST_FHI]),
    .b_i   (fs_9),
    .r_o   (tq_s)
  );

  // The forces ride along with the torque stages; stage 12 clamps the torques.
  always_ff @(posedge clk_i) begin
    if (en[ST_TQ]) begin
      fm_q[0] <= fm_9;
      fs_q[0] <= fs_9;
    end
    for (int s = 1; s <= ST_OUT - ST_TQ; s++) begin
      if (en[ST_TQ+s]) begin
        fm_q[s] <= fm_q[s-1];
        fs_q[s] <= fs_q[s-1];
      end
    end
    if (en[ST_OUT]) begin
      for (int i = 0; i < 3; i++) begin
        tm_q[i] <= CB'(csdf_pkg::sat_wide(64'(tq_m[i]), CB));
        ts_q[i] <= CB'(csdf_pkg::sat_wide(64'(tq_s[i]), CB));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_item_o.master_force[i*CB +: CB]  = fm_q[ST_OUT-ST_TQ][i];
      out_item_o.sub_force[i*CB +: CB]     = fs_q[ST_OUT-ST_TQ][i];
      out_item_o.master_torque[i*CB +: CB] = tm_q[i];
      out_item_o.sub_torque[i*CB +: CB]    = ts_q[i];
    end
  end

  // An empty output stage means the whole chain of stage enables is open.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[ST_OUT] |-> in_ready_o)
    else $error("input stalled while the output stage is empty");

  // A valid item in the first force unit stage is never dropped while it waits.
  a_force_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ST_FLO] && !en[ST_FLO+1] |=> valid_q[ST_FLO])
    else $error("item lost in a stalled stage");

  // A spring gain write lands in the register on the next cycle.
  a_cfg_spring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && (cfg_index_i == csdf_pkg::REG_SPRING_GAIN)
    |=> spring_gain_q == $past(cfg_data_i))
    else $error("spring gain write not applied");

  // The sub force x is the negated master force x except at the most negative value.
  a_sub_force_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (fm_q[ST_OUT-ST_TQ][0] != {1'b1, {(CB-1){1'b0}}})
    |-> fs_q[ST_OUT-ST_TQ][0] == -fm_q[ST_OUT-ST_TQ][0])
    else $error("sub force x is not the negated master force");

endmodule
